/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the ladder button debouncer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define LDB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define LDB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/ldb_pkg.sv */
// Package for the ladder button debouncer: constants, register indexes and types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ldb_pkg;

    localparam int BUTTON_COUNT = 5;
    localparam int CLASS_W      = 3;
    localparam int BUDGET_W     = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int FILL_W       = 2;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'hFFFF;
    localparam logic [FILL_W-1:0]   FILL_FULL    = 2'd2;

    typedef logic [CLASS_W-1:0] t_class;

    localparam t_class CLASS_NONE = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_ONE   = 3'd0,
        REG_WINDOW_TWO   = 3'd1,
        REG_WINDOW_THREE = 3'd2,
        REG_WINDOW_FOUR  = 3'd3,
        REG_WINDOW_FIVE  = 3'd4,
        REG_READ_BUDGET  = 3'd5
    } t_reg_idx;

    // Decision of the debounce logic for one reading.
    typedef struct packed {
        logic   fire;
        t_class button;
        logic   timed_out;
    } t_ldb_result;

endpackage

`default_nettype wire

/* hw/rtl/ldb_classify.sv */
// Window classifier: maps one reading to button 1..5, or 0 when no window holds it.
// Depends on ldb_pkg.
`default_nettype none

module ldb_classify #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    input  logic [2*SAMPLE_BITS-1:0] i_windows [ldb_pkg::BUTTON_COUNT],
    output ldb_pkg::t_class          o_class
);
    import ldb_pkg::*;

    logic [BUTTON_COUNT-1:0] w_hit;

    always_comb begin
        for (int k = 0; k < BUTTON_COUNT; k++) begin
            w_hit[k] = (i_sample >= i_windows[k][SAMPLE_BITS-1:0]) &&
                       (i_sample <= i_windows[k][2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
    end

    // The lowest-numbered matching window wins, so scan from the top down.
    always_comb begin
        o_class = CLASS_NONE;
        for (int k = BUTTON_COUNT - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                o_class = CLASS_W'(k + 1);
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ldb_history.sv */
// Debounce history: last two classes, fill count and read budget countdown.
// Depends on ldb_pkg and assert_macros.svh.
`default_nettype none

module ldb_history (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  ldb_pkg::t_class                i_class,
    input  logic                           i_budget_we,
    input  logic [ldb_pkg::BUDGET_W-1:0]   i_budget,
    output ldb_pkg::t_ldb_result           o_result
);
    import ldb_pkg::*;
    `include "assert_macros.svh"

    logic [BUDGET_W-1:0] r_budget;
    logic [BUDGET_W-1:0] r_reads_left;
    logic [BUDGET_W-1:0] n_reads_left;
    t_class              r_last;
    t_class              n_last;
    t_class              r_older;
    t_class              n_older;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;

    always_comb begin
        o_result     = '0;
        n_reads_left = r_reads_left;
        n_last       = r_last;
        n_older      = r_older;
        n_fill       = r_fill;
        if (r_reads_left == '0) begin
            // Budget spent: a timeout outranks any agreement on this reading.
            o_result.fire      = 1'b1;
            o_result.timed_out = 1'b1;
        end else if (r_fill == FILL_FULL && i_class == r_last && i_class == r_older) begin
            o_result.fire   = 1'b1;
            o_result.button = i_class;
        end else begin
            n_reads_left = r_reads_left - 1'b1;
            n_older      = r_last;
            n_last       = i_class;
            if (r_fill != FILL_FULL) begin
                n_fill = r_fill + 1'b1;
            end
        end
        if (o_result.fire) begin
            n_reads_left = r_budget;
            n_last       = CLASS_NONE;
            n_older      = CLASS_NONE;
            n_fill       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget     <= BUDGET_RESET;
            r_reads_left <= BUDGET_RESET;
            r_last       <= CLASS_NONE;
            r_older      <= CLASS_NONE;
            r_fill       <= '0;
        end else if (i_budget_we) begin
            // A new budget restarts the countdown but keeps the history.
            r_budget     <= i_budget;
            r_reads_left <= i_budget;
        end else if (i_step) begin
            r_reads_left <= n_reads_left;
            r_last       <= n_last;
            r_older      <= n_older;
            r_fill       <= n_fill;
        end
    end

    // While reset is held the fill count may still be unknown, so only its value after reset counts.
    `LDB_ASSERT_ALWAYS(a_fill_range, i_clk, (!i_rst_n || r_fill != 2'd3), "history fill count out of range")
    `LDB_ASSERT(a_clear_after_result, i_clk, i_rst_n, (i_step && !i_budget_we && o_result.fire) |=> (r_fill == '0 && r_last == CLASS_NONE && r_older == CLASS_NONE), "history not cleared after a result")
    `LDB_ASSERT(a_reload_after_result, i_clk, i_rst_n, (i_step && !i_budget_we && o_result.fire) |=> (r_reads_left == r_budget), "read countdown not reloaded after a result")

endmodule

`default_nettype wire

/* hw/rtl/ladder_button_debouncer_unit.sv */
// Ladder button debouncer: the result register offers a result once the reading that settles it
// has passed the input register; one reading is accepted per cycle while no result stalls,
// through the single classify-and-update stage between the input and result registers.
// Readings that settle nothing give no result; a stalled result holds back the stage behind it.
// Synchronous active-low reset empties both stages, restores empty windows, a full read budget
// and a clear history. Depends on ldb_pkg, ldb_classify, ldb_history and assert_macros.svh.
`default_nettype none

module ladder_button_debouncer_unit #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ldb_pkg::CLASS_W-1:0]     o_button,
    output logic                            o_timed_out,
    input  logic                            i_cfg_we,
    input  logic [ldb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [2*SAMPLE_BITS-1:0]        i_cfg_data
);
    import ldb_pkg::*;
    `include "assert_macros.svh"

    localparam int WinW = 2 * SAMPLE_BITS;
    // Reset window: low bound all ones above a high bound of zero, which never matches.
    localparam logic [WinW-1:0] WinReset = {{SAMPLE_BITS{1'b0}}, {SAMPLE_BITS{1'b1}}};

    logic [WinW-1:0]        r_win [BUTTON_COUNT];
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic                   r_out_valid;
    t_class                 r_button;
    logic                   r_timed_out;
    logic                   w_advance;
    logic                   w_budget_we;
    t_class                 w_class;
    t_ldb_result            w_res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BUTTON_COUNT; k++) begin
                r_win[k] <= WinReset;
            end
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WINDOW_ONE:   r_win[0] <= i_cfg_data;
                REG_WINDOW_TWO:   r_win[1] <= i_cfg_data;
                REG_WINDOW_THREE: r_win[2] <= i_cfg_data;
                REG_WINDOW_FOUR:  r_win[3] <= i_cfg_data;
                REG_WINDOW_FIVE:  r_win[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_budget_we = i_cfg_we && (t_reg_idx'(i_cfg_index) == REG_READ_BUDGET);

    // The stage moves on when the result register is free or is being emptied this cycle.
    assign w_advance  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_sample <= i_sample;
        end
    end

    ldb_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .i_sample  (r_s1_sample),
        .i_windows (r_win),
        .o_class   (w_class)
    );

    ldb_history u_history (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_class     (w_class),
        .i_budget_we (w_budget_we),
        .i_budget    (i_cfg_data[BUDGET_W-1:0]),
        .o_result    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res.fire;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res.fire) begin
            r_button    <= w_res.button;
            r_timed_out <= w_res.timed_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_button    = r_button;
    assign o_timed_out = r_timed_out;

    `LDB_ASSERT(a_timeout_no_button, i_clk, i_rst_n, (o_out_valid && o_timed_out) |-> (o_button == CLASS_NONE), "timeout result carries a button")
    `LDB_ASSERT(a_button_range, i_clk, i_rst_n, o_out_valid |-> (o_button <= CLASS_W'(BUTTON_COUNT)), "button number out of range")
    `LDB_ASSERT(a_stage_held, i_clk, i_rst_n, (r_s1_valid && !w_advance) |=> (r_s1_valid && $stable(r_s1_sample)), "held reading lost while the result stalls")

endmodule

`default_nettype wire

/* tb/ladder_button_debouncer_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ladder_button_debouncer_unit: a directed table, then random phases.
// Depends on ldb_pkg and the RTL of the block; results are checked against a debounce predictor.

module ladder_button_debouncer_unit_tb;
    import ldb_pkg::*;

    localparam int SMP_W           = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int PHASE_COUNT     = 6;

    // Indexes beyond the register map; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_SIX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_SEVEN = 3'd7;

    localparam logic [SMP_W-1:0] SMP_MAX = '1;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RESULT} t_chk;
    typedef enum logic {ROW_WRITE, ROW_READ} t_row_kind;
    typedef enum logic [1:0] {SETUP_LADDER, SETUP_SCATTER, SETUP_NESTED} t_setup;

    typedef struct packed {
        logic [CLASS_W-1:0] button;
        logic               timed_out;
    } t_key_result;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [2*SMP_W-1:0]     data;
        logic [SMP_W-1:0]       reading;
        t_chk                   chk;
        t_key_result            res;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [SMP_W-1:0]       i_sample;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [CLASS_W-1:0]     o_button;
    logic                   o_timed_out;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [2*SMP_W-1:0]     i_cfg_data;

    // Predictor copy of the configuration and the debounce state.
    logic [SMP_W-1:0]       win_lo [BUTTON_COUNT];
    logic [SMP_W-1:0]       win_hi [BUTTON_COUNT];
    logic [BUDGET_W-1:0]    budget_q;
    logic [BUDGET_W-1:0]    reads_rem;
    t_class                 newest_cls;
    t_class                 prior_cls;
    logic [FILL_W-1:0]      fill_cnt;

    t_key_result            pending_q [$];
    int                     n_err   = 0;
    int                     n_taken = 0;
    bit                     idle_on = 1'b1;
    t_chk                   cur_chk = CHK_MODEL;
    t_key_result            cur_res = '0;

    ladder_button_debouncer_unit #(
        .SAMPLE_BITS (SMP_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_button    (o_button),
        .o_timed_out (o_timed_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Walking downwards leaves the lowest-numbered matching window as the class.
    function automatic t_class classify_reading(input logic [SMP_W-1:0] s);
        t_class c;
        c = CLASS_NONE;
        for (int k = BUTTON_COUNT - 1; k >= 0; k--) begin
            if (s >= win_lo[k] && s <= win_hi[k]) c = t_class'(k + 1);
        end
        return c;
    endfunction

    function automatic void restart_history();
        newest_cls = CLASS_NONE;
        prior_cls  = CLASS_NONE;
        fill_cnt   = '0;
        reads_rem  = budget_q;
    endfunction

    function automatic bit debounce_step(input logic [SMP_W-1:0] s, output t_key_result r);
        t_class c;
        c = classify_reading(s);
        r = '0;
        // An exhausted budget reports a timeout even if this reading would agree.
        if (reads_rem == '0) begin
            r.timed_out = 1'b1;
            restart_history();
            return 1'b1;
        end
        reads_rem = reads_rem - 1'b1;
        if (fill_cnt >= FILL_FULL && c == newest_cls && c == prior_cls) begin
            r.button = c;
            restart_history();
            return 1'b1;
        end
        prior_cls  = newest_cls;
        newest_cls = c;
        if (fill_cnt < FILL_FULL) fill_cnt = fill_cnt + 1'b1;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_key_result got;
        t_key_result want;
        bit          fired;
        if (!i_rst_n) begin
            for (int k = 0; k < BUTTON_COUNT; k++) begin
                win_lo[k] = SMP_MAX;
                win_hi[k] = '0;
            end
            budget_q = BUDGET_RESET;
            restart_history();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WINDOW_ONE, REG_WINDOW_TWO, REG_WINDOW_THREE,
                    REG_WINDOW_FOUR, REG_WINDOW_FIVE: begin
                        win_lo[i_cfg_index] = i_cfg_data[SMP_W-1:0];
                        win_hi[i_cfg_index] = i_cfg_data[2*SMP_W-1:SMP_W];
                    end
                    REG_READ_BUDGET: begin
                        budget_q  = i_cfg_data[BUDGET_W-1:0];
                        reads_rem = budget_q;
                    end
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                got.button    = o_button;
                got.timed_out = o_timed_out;
                if (pending_q.size() == 0) begin
                    $error("unexpected result: button %0d, timed_out %0d",
                           got.button, got.timed_out);
                    n_err++;
                end else begin
                    want = pending_q.pop_front();
                    if (got.button !== want.button) begin
                        $error("button: expected %0d, actual %0d", want.button, got.button);
                        n_err++;
                    end
                    if (got.timed_out !== want.timed_out) begin
                        $error("timed_out: expected %0d, actual %0d",
                               want.timed_out, got.timed_out);
                        n_err++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                fired = debounce_step(i_sample, want);
                n_taken++;
                case (cur_chk)
                    CHK_MODEL:  if (fired) pending_q.push_back(want);
                    CHK_RESULT: pending_q.push_back(cur_res);
                    default: ;
                endcase
            end
        end
    end

    // Offers one reading and returns at the falling edge after its transfer.
    task automatic send_reading(input logic [SMP_W-1:0] s, input t_chk chk,
                                input t_key_result res);
        int seen;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        cur_chk     = chk;
        cur_res     = res;
        seen        = n_taken;
        do @(negedge i_clk); while (n_taken == seen);
    endtask

    // Holds the sender back until every result is in and the pipeline has emptied.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [2*SMP_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_row write_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [2*SMP_W-1:0] data);
        t_row r;
        r.kind    = ROW_WRITE;
        r.idx     = idx;
        r.data    = data;
        r.reading = '0;
        r.chk     = CHK_NONE;
        r.res     = '0;
        return r;
    endfunction

    function automatic t_row read_row(input logic [SMP_W-1:0] s, input t_chk chk,
                                      input int btn, input bit tmo);
        t_row r;
        r.kind          = ROW_READ;
        r.idx           = '0;
        r.data          = '0;
        r.reading       = s;
        r.chk           = chk;
        r.res.button    = t_class'(btn);
        r.res.timed_out = tmo;
        return r;
    endfunction

    function automatic logic [2*SMP_W-1:0] pack_window(input int lo, input int hi);
        return {SMP_W'(hi), SMP_W'(lo)};
    endfunction

    task automatic load_random_setup(input t_setup mode, input logic [BUDGET_W-1:0] budget);
        int lo;
        int hi;
        int band;
        band = (1 << SMP_W) / BUTTON_COUNT;
        for (int k = 0; k < BUTTON_COUNT; k++) begin
            case (mode)
                SETUP_LADDER: begin
                    lo = k * band + $urandom_range(0, 40);
                    hi = (k + 1) * band - $urandom_range(1, 40);
                end
                SETUP_SCATTER: begin
                    lo = $urandom_range(0, SMP_MAX);
                    hi = $urandom_range(0, SMP_MAX);
                end
                default: begin
                    // Narrow windows over a catch-all fifth window.
                    if (k == BUTTON_COUNT - 1) begin
                        lo = 0;
                        hi = SMP_MAX;
                    end else begin
                        lo = $urandom_range(0, SMP_MAX);
                        hi = lo + $urandom_range(0, 120);
                        if (hi > SMP_MAX) hi = SMP_MAX;
                    end
                end
            endcase
            write_reg(CFG_IDX_W'(int'(REG_WINDOW_ONE) + k), pack_window(lo, hi));
        end
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? REG_SPARE_SIX : REG_SPARE_SEVEN,
                      (2*SMP_W)'($urandom));
        write_reg(REG_READ_BUDGET, {4'($urandom), budget});
    endtask

    function automatic logic [SMP_W-1:0] pick_reading(input int k, input bit noisy);
        int sel;
        if (noisy || win_lo[k] > win_hi[k]) begin
            sel = $urandom_range(0, 3);
            if (sel == 0) return $urandom_range(0, 1) ? SMP_MAX : '0;
            return SMP_W'($urandom);
        end
        sel = $urandom_range(0, 7);
        if (sel == 0) return win_lo[k];
        if (sel == 1) return win_hi[k];
        return SMP_W'($urandom_range(win_hi[k], win_lo[k]));
    endfunction

    // Mostly runs of readings within one window, as a held button gives, with some noise.
    task automatic run_random_phase(input int count);
        int sent;
        int run_len;
        int k;
        bit junk;
        sent = 0;
        while (sent < count) begin
            k       = $urandom_range(0, BUTTON_COUNT - 1);
            run_len = $urandom_range(1, 6);
            junk    = ($urandom_range(0, 7) == 0);
            for (int n = 0; n < run_len && sent < count; n++) begin
                send_reading(pick_reading(k, junk || $urandom_range(0, 9) == 0), CHK_MODEL, '0);
                sent++;
            end
        end
    endtask

    initial begin : sink
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_row dir_tab [$];
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_WINDOW_ONE;
        i_cfg_data  = '0;

        // After reset every window is empty, so all readings are class none, and
        // two stored classes are needed before even class none can agree.
        dir_tab.push_back(read_row('0, CHK_NONE, 0, 0));
        dir_tab.push_back(read_row(SMP_MAX, CHK_NONE, 0, 0));
        dir_tab.push_back(read_row(10'd512, CHK_RESULT, 0, 0));
        dir_tab.push_back(write_row(REG_WINDOW_ONE,   pack_window(0, 100)));
        dir_tab.push_back(write_row(REG_WINDOW_TWO,   pack_window(50, 300)));
        dir_tab.push_back(write_row(REG_WINDOW_THREE, pack_window(301, 600)));
        dir_tab.push_back(write_row(REG_WINDOW_FOUR,  pack_window(700, SMP_MAX)));
        dir_tab.push_back(write_row(REG_WINDOW_FIVE,  pack_window(650, 640)));
        dir_tab.push_back(write_row(REG_READ_BUDGET,  20'd5));
        // Overlapping windows: button one wins.
        dir_tab.push_back(read_row(10'd60, CHK_NONE, 0, 0));
        dir_tab.push_back(read_row(10'd60, CHK_NONE, 0, 0));
        dir_tab.push_back(read_row(10'd60, CHK_RESULT, 1, 0));
        dir_tab.push_back(read_row(SMP_MAX, CHK_NONE, 0, 0));
        dir_tab.push_back(read_row(SMP_MAX, CHK_NONE, 0, 0));
        dir_tab.push_back(read_row(SMP_MAX, CHK_RESULT, 4, 0));
        // Inside the empty fifth window only.
        dir_tab.push_back(read_row(10'd645, CHK_NONE, 0, 0));
        dir_tab.push_back(read_row(10'd645, CHK_NONE, 0, 0));
        dir_tab.push_back(read_row(10'd645, CHK_RESULT, 0, 0));
        // Budget runs out just as the last two classes agree: the timeout wins.
        dir_tab.push_back(read_row(10'd400, CHK_MODEL, 0, 0));
        dir_tab.push_back(read_row(10'd0,   CHK_MODEL, 0, 0));
        dir_tab.push_back(read_row(10'd400, CHK_MODEL, 0, 0));
        dir_tab.push_back(read_row(10'd0,   CHK_MODEL, 0, 0));
        dir_tab.push_back(read_row(10'd0,   CHK_MODEL, 0, 0));
        dir_tab.push_back(read_row(10'd100, CHK_RESULT, 0, 1));
        // A budget write keeps the history; the upper data bits are dropped.
        dir_tab.push_back(read_row(10'd0, CHK_MODEL, 0, 0));
        dir_tab.push_back(read_row(10'd0, CHK_MODEL, 0, 0));
        dir_tab.push_back(write_row(REG_READ_BUDGET, 20'hF0003));
        dir_tab.push_back(read_row(10'd50, CHK_RESULT, 1, 0));
        dir_tab.push_back(write_row(REG_SPARE_SIX, '1));
        dir_tab.push_back(write_row(REG_SPARE_SEVEN, '0));
        // With no budget every reading times out.
        dir_tab.push_back(write_row(REG_READ_BUDGET, '0));
        dir_tab.push_back(read_row('0, CHK_RESULT, 0, 1));
        dir_tab.push_back(read_row(SMP_MAX, CHK_RESULT, 0, 1));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_WRITE) begin
                settle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_reading(dir_tab[i].reading, dir_tab[i].chk, dir_tab[i].res);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p == PHASE_COUNT - 1) idle_on = 1'b0;
            settle();
            case (p)
                0:       load_random_setup(SETUP_LADDER, BUDGET_RESET);
                1:       load_random_setup(SETUP_LADDER, BUDGET_W'($urandom_range(1, 12)));
                2:       load_random_setup(SETUP_SCATTER, '0);
                3:       load_random_setup(SETUP_NESTED, BUDGET_W'($urandom_range(2, 6)));
                4:       load_random_setup(SETUP_SCATTER, BUDGET_W'($urandom));
                default: load_random_setup(SETUP_LADDER, BUDGET_W'($urandom_range(3, 10)));
            endcase
            run_random_phase(ITEMS_PER_PHASE);
        end

        settle();
        if (n_err == 0 && pending_q.size() == 0) begin
            $display("PASS ladder_button_debouncer_unit");
        end else begin
            $display("FAIL ladder_button_debouncer_unit");
        end
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("FAIL ladder_button_debouncer_unit");
        $finish;
    end

endmodule
